// File: rtl/core/interval_overlap_matcher_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the interval overlap matcher
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_OVERLAP_MATCHER_ASSERT_SVH
`define INTERVAL_OVERLAP_MATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define IOM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IOM_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define IOM_ASSERT(label, clk, rst_n, prop)
`define IOM_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: rtl/core/iom_pkg.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher package
// Shared widths, codes, payload structs and the front-to-back request type.
// ---------------------------------------------------------------------------
package iom_pkg;
    localparam int MaxRegions = 64;
    localparam int SlotBits   = 6;
    localparam int CountBits  = 7;
    localparam int ChromBits  = 6;
    localparam int CoordBits  = 31;
    localparam int PctBits    = 14;
    localparam int ModeBits   = 2;
    localparam int CfgIdxBits = 2;
    localparam int Scale      = 10000;
    localparam int QDepth     = 4;
    localparam int QPtrBits   = 2;
    localparam int ProdBits   = CoordBits + 15;
    localparam int DivBits    = PctBits + 1;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    localparam logic [CfgIdxBits-1:0] CfgMode   = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgCutoff = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgInUse  = 2'd2;

    localparam logic [ModeBits-1:0] ModeUnion  = 2'd0;
    localparam logic [ModeBits-1:0] ModeRegion = 2'd1;
    localparam logic [ModeBits-1:0] ModeQuery  = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [SlotBits-1:0]  slot;
        logic [ChromBits-1:0] chrom;
        logic [CoordBits-1:0] start_pos;
        logic [CoordBits-1:0] stop_pos;
    } t_in_item;

    typedef struct packed {
        logic [SlotBits-1:0] region_slot;
        logic [PctBits-1:0]  percent_hundredths;
        logic                none_found;
        logic                last;
    } t_out_item;

    // request handed from front to back
    typedef struct packed {
        logic                 op;
        logic [SlotBits-1:0]  slot;
        logic [ChromBits-1:0] chrom;
        logic [CoordBits-1:0] qs;
        logic [CoordBits-1:0] qe;
        logic                 q_bad;
        logic [CountBits-1:0] n;
    } t_req;
endpackage

// File: rtl/core/iom_front.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher front end
// Accepts items, classifies them and queues loads and queries in order.
// ---------------------------------------------------------------------------
module iom_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  iom_pkg::t_in_item             i_item,
    input  logic [iom_pkg::CountBits-1:0] i_in_use,
    output logic                          o_req_valid,
    output iom_pkg::t_req                 o_req,
    input  logic                          i_req_take
);
    import iom_pkg::*;

    t_req                r_q [QDepth];
    logic [QPtrBits-1:0] r_wp, r_rp;
    logic [QPtrBits:0]   r_cnt;
    logic                acc, qpush;
    t_req                nreq;

    assign full   = (r_cnt == (QPtrBits+1)'(QDepth));
    assign acc    = push && !full;
    assign qpush  = acc;

    always_comb begin
        nreq.op    = i_item.opcode;
        nreq.slot  = i_item.slot;
        nreq.chrom = i_item.chrom;
        nreq.qs    = i_item.start_pos;
        nreq.qe    = i_item.stop_pos;
        nreq.q_bad = i_item.stop_pos < i_item.start_pos;
        nreq.n     = (i_in_use > CountBits'(MaxRegions)) ? CountBits'(MaxRegions) : i_in_use;
    end

    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (qpush) begin
            r_q[r_wp] <= nreq;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (qpush) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_req_take && o_req_valid) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPtrBits+1)'(qpush) - (QPtrBits+1)'(i_req_take && o_req_valid);
        end
    end

`include "interval_overlap_matcher_assert.svh"
    `IOM_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= (QPtrBits+1)'(QDepth))
    `IOM_ASSERT(a_no_push_full, i_clk, i_rst_n, full |-> !qpush)
    `IOM_ASSERT(a_take_valid, i_clk, i_rst_n, i_req_take |-> o_req_valid)
endmodule

// File: rtl/core/iom_div.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher divider
// Restoring divider, one quotient bit per cycle, for the rounded percent.
// ---------------------------------------------------------------------------
module iom_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [iom_pkg::ProdBits-1:0] i_num,
    input  logic [iom_pkg::CoordBits:0]  i_den,
    output logic                         o_done,
    output logic [iom_pkg::PctBits-1:0]  o_quot
);
    import iom_pkg::*;

    localparam int CntBits = 4;

    logic [ProdBits-1:0]  r_rem;
    logic [CoordBits:0]   r_den;
    logic [DivBits-1:0]   r_quot;
    logic [CntBits-1:0]   r_cnt;
    logic                 r_busy, r_done;
    logic [ProdBits:0]    trial, shd;

    always_comb begin
        shd   = {1'b0, r_rem} - ({(ProdBits-CoordBits)'(0), r_den} << r_cnt);
        trial = shd;
    end

    assign o_done = r_done;
    assign o_quot = r_quot[PctBits-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
            r_cnt  <= CntBits'(DivBits-1);
        end else if (r_busy) begin
            if (!trial[ProdBits]) begin
                r_rem <= trial[ProdBits-1:0];
            end
            r_quot <= {r_quot[DivBits-2:0], !trial[ProdBits]};
            r_cnt  <= r_cnt - 1'b1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// File: rtl/core/iom_back.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher back end
// Writes loads into the region table, walks it for each query, tests each
// region and emits results.
// ---------------------------------------------------------------------------
module iom_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  iom_pkg::t_req                 i_req,
    output logic                          o_req_take,
    input  logic [iom_pkg::ModeBits-1:0]  i_mode,
    input  logic [iom_pkg::PctBits-1:0]   i_cutoff,
    output logic                          empty,
    input  logic                          pop,
    output iom_pkg::t_out_item            o_item
);
    import iom_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_TEST, S_CMP, S_DIV, S_OUT, S_NEXT
    } t_state;

    logic [ChromBits-1:0] mem_chrom [MaxRegions];
    logic [CoordBits-1:0] mem_start [MaxRegions];
    logic [CoordBits-1:0] mem_stop  [MaxRegions];

    t_state               r_state;
    t_req                 r_req;
    logic [CountBits-1:0] r_idx;
    logic                 r_any;
    logic                 r_fin;
    logic [ChromBits-1:0] r_rc;
    logic [CoordBits-1:0] r_rs, r_re;
    logic [CoordBits-1:0] r_ov;
    logic [CoordBits-1:0] r_den;
    logic                 r_ok;
    logic [ProdBits-1:0]  r_lhs, r_rhs;
    logic                 r_oval;
    t_out_item            r_out;
    logic [SlotBits-1:0]  r_pslot;
    logic [PctBits-1:0]   r_ppct;

    logic [CoordBits-1:0] lo, hi, ulo, uhi, den;
    logic                 pair_ok;
    logic                 div_start, div_done;
    logic [PctBits-1:0]   div_q;
    logic                 is_last;

    always_ff @(posedge i_clk) begin
        if (o_req_take && (i_req.op == OpLoad)) begin
            mem_chrom[i_req.slot] <= i_req.chrom;
            mem_start[i_req.slot] <= i_req.qs;
            mem_stop[i_req.slot]  <= i_req.qe;
        end
        r_rc <= mem_chrom[r_idx[SlotBits-1:0]];
        r_rs <= mem_start[r_idx[SlotBits-1:0]];
        r_re <= mem_stop[r_idx[SlotBits-1:0]];
    end

    always_comb begin
        lo  = (r_req.qs > r_rs) ? r_req.qs : r_rs;
        hi  = (r_req.qe < r_re) ? r_req.qe : r_re;
        ulo = (r_req.qs < r_rs) ? r_req.qs : r_rs;
        uhi = (r_req.qe > r_re) ? r_req.qe : r_re;
        unique case (i_mode)
            ModeUnion:  den = uhi - ulo;
            ModeRegion: den = r_re - r_rs;
            ModeQuery:  den = r_req.qe - r_req.qs;
            default:    den = '0;
        endcase
        pair_ok = (r_rc == r_req.chrom) && !r_req.q_bad && (r_re >= r_rs) && (hi > lo)
                  && (den != '0);
    end

    assign is_last   = (r_idx + 1'b1) >= r_req.n;
    assign div_start = (r_state == S_CMP) && !r_ok && (r_lhs > r_rhs);
    assign o_req_take = (r_state == S_IDLE) && i_req_valid;
    assign empty  = !r_oval;
    assign o_item = r_out;

    iom_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (ProdBits'({r_ov, 1'b0}) * ProdBits'(Scale) + ProdBits'(r_den)),
        .i_den   ({r_den, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_idx   <= '0;
            r_any   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            if (pop && r_oval && (r_state != S_OUT)) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && (i_req.op == OpQuery)) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_any   <= 1'b0;
                        r_pslot <= '0;
                        r_ppct  <= '0;
                        r_fin   <= (i_req.n == '0);
                        r_state <= (i_req.n == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ: r_state <= S_TEST;
                S_TEST: begin
                    r_ov  <= hi - lo;
                    r_den <= den;
                    r_ok  <= pair_ok;
                    r_state <= pair_ok ? S_CMP : S_NEXT;
                end
                S_CMP: begin
                    if (r_ok) begin
                        r_lhs <= ProdBits'(r_ov) * ProdBits'(Scale);
                        r_rhs <= ProdBits'(r_den) * ProdBits'(i_cutoff);
                        r_ok  <= 1'b0;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_any) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pslot <= r_idx[SlotBits-1:0];
                            r_ppct  <= div_q;
                            r_any   <= 1'b1;
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_oval || pop) begin
                        r_oval <= 1'b1;
                        r_out.region_slot <= r_pslot;
                        r_out.percent_hundredths <= r_ppct;
                        r_out.none_found <= !r_any;
                        r_out.last <= r_fin;
                        if (r_fin) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pslot <= r_idx[SlotBits-1:0];
                            r_ppct  <= div_q;
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (is_last) begin
                        r_fin   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "interval_overlap_matcher_assert.svh"
    `IOM_ASSERT(a_take_idle, i_clk, i_rst_n, (o_req_take && (i_req.op == OpQuery)) |=> (r_state != S_IDLE))
    `IOM_ASSERT(a_out_hold, i_clk, i_rst_n, (r_oval && !pop) |=> $stable(r_out))
    `IOM_ASSERT(a_pct_range, i_clk, i_rst_n,
        (r_oval && !r_out.none_found) |-> (r_out.percent_hundredths <= PctBits'(Scale)))
endmodule

// File: rtl/core/interval_overlap_matcher.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher
// Holds up to 64 regions; each query reports every region on its
// chromosome whose overlap fraction beats the cutoff, with the percent.
// Loads and queries pass in order through a four-entry request queue; a
// load is written into the table when the idle back end takes it from
// the head, so it never overtakes an earlier query. A query walks the
// first regions_in_use slots: each slot is read and given the pair test,
// one that passes is held to the cutoff, and one that beats the cutoff
// gets its percent from the bit-serial divider. A hit is held until the
// next hit or the end of the walk so that its last flag is known. Results
// wait in one output register, and a result that is not popped stalls the
// walk. Registers are to be written only while the block is idle.
// ---------------------------------------------------------------------------
module interval_overlap_matcher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  iom_pkg::t_in_item                  i_item,
    output logic                               empty,
    input  logic                               pop,
    output iom_pkg::t_out_item                 o_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [iom_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  logic [iom_pkg::PctBits-1:0]        i_cfg_data
);
    import iom_pkg::*;

    logic [ModeBits-1:0]  r_mode;
    logic [PctBits-1:0]   r_cutoff;
    logic [CountBits-1:0] r_in_use;
    logic                 req_valid, req_take;
    t_req                 req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_cutoff <= '0;
            r_in_use <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgMode:   r_mode   <= i_cfg_data[ModeBits-1:0];
                CfgCutoff: r_cutoff <= i_cfg_data;
                CfgInUse:  r_in_use <= i_cfg_data[CountBits-1:0];
                default: ;
            endcase
        end
    end

    iom_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_in_use    (r_in_use),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_take  (req_take)
    );

    iom_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .i_mode      (r_mode),
        .i_cutoff    (r_cutoff),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );
endmodule

// File: bench/interval_overlap_matcher_tb.sv
// ---------------------------------------------------------------------------
// Interval overlap matcher testbench
// Loads regions and sends queries through the queue-style ports, with bursty
// requests and a stalling result side. A scoreboard predicts every result
// and checks each popped result in order. Register settings change between
// phases, only while the block is drained.
// ---------------------------------------------------------------------------
module interval_overlap_matcher_tb;
    import iom_pkg::*;

    class overlap_scoreboard;
        logic [ChromBits-1:0] tbl_chrom [MaxRegions];
        logic [CoordBits-1:0] tbl_start [MaxRegions];
        logic [CoordBits-1:0] tbl_stop  [MaxRegions];
        logic [ModeBits-1:0]  mode;
        logic [PctBits-1:0]   cutoff;
        logic [CountBits-1:0] in_use;
        t_out_item            pending_hits[$];
        int                   errors;

        function new();
            mode = ModeUnion;
            cutoff = '0;
            in_use = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxBits-1:0] idx, logic [PctBits-1:0] data);
            case (idx)
                CfgMode:   mode = data[ModeBits-1:0];
                CfgCutoff: cutoff = data;
                CfgInUse:  in_use = data[CountBits-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_in_item it);
            longint unsigned qs, qe, rs, re, lo, hi, ov, den;
            int        n, hits;
            t_out_item r;
            if (it.opcode == OpLoad) begin
                tbl_chrom[it.slot] = it.chrom;
                tbl_start[it.slot] = it.start_pos;
                tbl_stop[it.slot]  = it.stop_pos;
                return;
            end
            qs = it.start_pos;
            qe = it.stop_pos;
            n = (in_use > MaxRegions) ? MaxRegions : in_use;
            hits = 0;
            for (int i = 0; i < n; i++) begin
                if (tbl_chrom[i] != it.chrom) continue;
                rs = tbl_start[i];
                re = tbl_stop[i];
                if (qe < qs || re < rs) continue;
                lo = (qs > rs) ? qs : rs;
                hi = (qe < re) ? qe : re;
                if (hi <= lo) continue;
                ov = hi - lo;
                case (mode)
                    ModeUnion:  den = ((qe > re) ? qe : re) - ((qs < rs) ? qs : rs);
                    ModeRegion: den = re - rs;
                    ModeQuery:  den = qe - qs;
                    default:    den = 0;
                endcase
                if (den == 0) continue;
                if (!(ov * Scale > longint'(cutoff) * den)) continue;
                r.region_slot = i[SlotBits-1:0];
                r.percent_hundredths = PctBits'((ov * Scale * 2 + den) / (den * 2));
                r.none_found = 1'b0;
                r.last = 1'b0;
                pending_hits.insert(pending_hits.size(), r);
                hits++;
            end
            if (hits == 0) begin
                r = '0;
                r.none_found = 1'b1;
                r.last = 1'b1;
                pending_hits.insert(pending_hits.size(), r);
            end else begin
                pending_hits[pending_hits.size()-1].last = 1'b1;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_hits.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CfgIdxBits-1:0] i_cfg_index = '0;
    logic [PctBits-1:0]    i_cfg_data = '0;

    overlap_scoreboard sb = new();
    bit [MaxRegions-1:0] loaded = '0;
    int stall_left = 0;
    int quiet_cnt = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    interval_overlap_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // result side: long quiet stretches alternate with random stalls
    always @(posedge i_clk) begin
        quiet_cnt <= (quiet_cnt + 1) % 900;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (quiet_cnt < 250) begin
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_item);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 20000) begin
            $display("interval_overlap_matcher: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_in_item it);
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_request(it);
        if (it.opcode == OpLoad) loaded[it.slot] = 1'b1;
    endtask

    task automatic cfg_write(logic [CfgIdxBits-1:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= PctBits'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, PctBits'(val));
    endtask

    task automatic configure(int mode, int cut, int use_n);
        cfg_write(CfgMode, mode);
        cfg_write(CfgCutoff, cut);
        cfg_write(CfgInUse, use_n);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_hits.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic op, int slot, int chrom, int s, int e);
        t_in_item it;
        it.opcode = op;
        it.slot = SlotBits'(slot);
        it.chrom = ChromBits'(chrom);
        it.start_pos = CoordBits'(s);
        it.stop_pos = CoordBits'(e);
        return it;
    endfunction

    function automatic int loaded_prefix();
        int n = 0;
        while (n < MaxRegions && loaded[n]) n++;
        return n;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int unsigned s, e, t;
        it.opcode = ($urandom_range(0, 99) < 35) ? OpLoad : OpQuery;
        it.slot = SlotBits'($urandom);
        if (it.opcode == OpLoad && loaded_prefix() < MaxRegions && $urandom_range(0, 1))
            it.slot = SlotBits'(loaded_prefix());
        it.chrom = ChromBits'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0) begin
            s = $urandom & 32'h7FFF_FFFF;
            e = $urandom & 32'h7FFF_FFFF;
        end else begin
            s = $urandom_range(0, 2000);
            e = s + $urandom_range(0, 800);
            if ($urandom_range(0, 9) == 0) begin
                t = s; s = e; e = t;
            end
        end
        it.start_pos = s[CoordBits-1:0];
        it.stop_pos = e[CoordBits-1:0];
        return it;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                push <= 1'b0;
                if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 15)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            send(random_item());
            burst_left--;
        end
        drain();
    endtask

    function automatic int pick_in_use();
        int p = loaded_prefix();
        case ($urandom_range(0, 3))
            0: return p;
            1: return 0;
            default: return $urandom_range(0, p);
        endcase
    endfunction

    function automatic int pick_cutoff();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 10000;
            2: return 16383;
            default: return $urandom_range(0, 9000);
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        configure(ModeUnion, 0, 8);

        send(mk(OpLoad, 0, 1, 100, 200));
        send(mk(OpLoad, 1, 1, 150, 300));
        send(mk(OpLoad, 2, 1, 300, 100));
        send(mk(OpLoad, 3, 1, 500, 500));
        send(mk(OpLoad, 4, 63, 0, 32'h7FFF_FFFF));
        send(mk(OpLoad, 5, 2, 0, 10));
        send(mk(OpLoad, 6, 1, 0, 1000));
        send(mk(OpLoad, 7, 63, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        send(mk(OpQuery, 63, 1, 120, 250));
        send(mk(OpQuery, 0, 1, 250, 120));
        send(mk(OpQuery, 0, 9, 0, 100));
        send(mk(OpQuery, 0, 63, 0, 32'h7FFF_FFFF));
        send(mk(OpQuery, 0, 2, 10, 20));
        send(mk(OpQuery, 0, 1, 150, 150));
        drain();
        configure(ModeRegion, 5000, 8);
        send(mk(OpQuery, 0, 1, 100, 200));
        send(mk(OpQuery, 0, 63, 1, 32'h7FFF_FFFF));
        drain();
        configure(ModeQuery, 3333, 8);
        send(mk(OpQuery, 0, 1, 100, 200));
        drain();
        configure(3, 0, 8);
        send(mk(OpQuery, 0, 1, 100, 200));
        drain();
        configure(ModeUnion, 10000, 8);
        send(mk(OpQuery, 0, 1, 100, 200));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            configure(($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2),
                      pick_cutoff(), pick_in_use());
            run_random(10);
        end

        for (int sl = 0; sl < MaxRegions; sl++) begin
            if (!loaded[sl]) send(mk(OpLoad, sl, $urandom_range(0, 3),
                                     $urandom_range(0, 1500), $urandom_range(200, 2500)));
        end
        drain();
        configure(ModeUnion, 0, 127);
        run_random(12);
        configure($urandom_range(0, 2), $urandom_range(0, 3000), MaxRegions);
        run_random(12);

        if (sb.pending_hits.size() == 0 && sb.errors == 0) begin
            $display("interval_overlap_matcher: match");
        end else begin
            $display("interval_overlap_matcher: mismatch");
        end
        $finish;
    end
endmodule
